// File: design/tcp_opt_pkg.sv
package tcp_opt_pkg;

   // Depth of the byte queue between the classifier and the option walker.
   localparam int QueueDepth = 4;

   // Option classes reported on the result channel.
   localparam logic [2:0] CLS_NOP       = 3'd0;
   localparam logic [2:0] CLS_MSS       = 3'd1;
   localparam logic [2:0] CLS_WSCALE    = 3'd2;
   localparam logic [2:0] CLS_SACK_PERM = 3'd3;
   localparam logic [2:0] CLS_SACK      = 3'd4;
   localparam logic [2:0] CLS_TIMESTAMP = 3'd5;
   localparam logic [2:0] CLS_OTHER     = 3'd6;

   // Parse status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EOL   = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;
   localparam logic [1:0] ST_TRUNC = 2'd3;

   // Option kind values that matter to the walker.
   localparam logic [7:0] KIND_EOL = 8'd0;
   localparam logic [7:0] KIND_NOP = 8'd1;

   // One options byte with the flags the walker needs, worked out up front.
   typedef struct packed {
      logic [7:0] opt_byte;
      logic       region_first;
      logic       region_last;
      logic [2:0] byte_class;
      logic       is_zero;
      logic       is_one;
      logic       is_two;
      logic       len_eq3;
      logic       len_eq4;
      logic       len_eq10;
   } byte_info_type;

   // One result word.
   typedef struct packed {
      logic [2:0]  option_class;
      logic [7:0]  option_kind;
      logic [7:0]  option_length;
      logic [31:0] value_first;
      logic [31:0] value_second;
      logic [1:0]  parse_status;
      logic        list_done;
   } rsp_word_type;

   function automatic logic [2:0] class_of(input logic [7:0] kind);
      logic [2:0] cls;
      unique case (kind)
         8'd1:    cls = CLS_NOP;
         8'd2:    cls = CLS_MSS;
         8'd3:    cls = CLS_WSCALE;
         8'd4:    cls = CLS_SACK_PERM;
         8'd5:    cls = CLS_SACK;
         8'd8:    cls = CLS_TIMESTAMP;
         default: cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

endpackage

// File: design/tcp_opt_if.sv
interface tcp_opt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] opt_byte;
   logic       region_first;
   logic       region_last;

   modport source (output valid, output opt_byte, output region_first,
                   output region_last, input ready);
   modport sink   (input valid, input opt_byte, input region_first,
                   input region_last, output ready);
endinterface

interface tcp_opt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  option_class;
   logic [7:0]  option_kind;
   logic [7:0]  option_length;
   logic [31:0] value_first;
   logic [31:0] value_second;
   logic [1:0]  parse_status;
   logic        list_done;

   modport source (output valid, output option_class, output option_kind,
                   output option_length, output value_first, output value_second,
                   output parse_status, output list_done, input ready);
   modport sink   (input valid, input option_class, input option_kind,
                   input option_length, input value_first, input value_second,
                   input parse_status, input list_done, output ready);
endinterface

// File: design/tcp_opt_front.sv
module tcp_opt_front import tcp_opt_pkg::*; (
   tcp_opt_req_if.sink   req_ch,
   input  logic          queue_full,
   output logic          push,
   output byte_info_type push_info
);

   // A byte is taken whenever the queue has room.
   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   always_comb begin
      push_info.opt_byte     = req_ch.opt_byte;
      push_info.region_first = req_ch.region_first;
      push_info.region_last  = req_ch.region_last;
      push_info.byte_class   = class_of(req_ch.opt_byte);
      push_info.is_zero      = (req_ch.opt_byte == 8'd0);
      push_info.is_one       = (req_ch.opt_byte == 8'd1);
      push_info.is_two       = (req_ch.opt_byte == 8'd2);
      push_info.len_eq3      = (req_ch.opt_byte == 8'd3);
      push_info.len_eq4      = (req_ch.opt_byte == 8'd4);
      push_info.len_eq10     = (req_ch.opt_byte == 8'd10);
   end

endmodule

// File: design/tcp_opt_queue.sv
module tcp_opt_queue import tcp_opt_pkg::*; #(
   parameter int DEPTH = QueueDepth
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  byte_info_type push_info,
   output logic          full,
   input  logic          pop,
   output byte_info_type pop_info,
   output logic          empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr  = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

   byte_info_type   slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == DepthCnt);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_info = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_info;
      end
   end

endmodule

// File: design/tcp_opt_back.sv
module tcp_opt_back import tcp_opt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          queue_empty,
   input  byte_info_type info,
   output logic          pop,
   tcp_opt_rsp_if.source rsp_ch
);

   localparam logic [1:0] PH_KIND = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   logic [1:0]   phase_ff, phase_in, eff_phase;
   logic [7:0]   kind_ff, kind_in;
   logic [2:0]   kcls_ff, kcls_in;
   logic [7:0]   dlen_ff, dlen_in;
   logic [7:0]   remain_ff, remain_in;
   logic [31:0]  acc1_ff, acc1_in;
   logic [31:0]  acc2_ff, acc2_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rec;
   logic         emit;
   logic         take;
   logic         len_ok;
   logic [31:0]  ok_v1, ok_v2;
   logic [7:0]   sack_len;

   // A byte is consumed when the output register is free or being emptied.
   assign take = !queue_empty && (!rsp_valid_ff || rsp_ch.ready);
   assign pop  = take;

   // A first mark restarts the walk at a kind byte.
   assign eff_phase = info.region_first ? PH_KIND : phase_ff;

   always_comb begin
      unique case (kcls_ff)
         CLS_MSS:       len_ok = info.len_eq4;
         CLS_WSCALE:    len_ok = info.len_eq3;
         CLS_SACK_PERM: len_ok = info.is_two;
         CLS_SACK:      len_ok = !info.is_zero && !info.is_one && !info.is_two;
         CLS_TIMESTAMP: len_ok = info.len_eq10;
         default:       len_ok = !info.is_zero && !info.is_one;
      endcase
   end

   // Values of a completed option, taken from the updated accumulators.
   assign sack_len = dlen_in - 8'd2;
   always_comb begin
      ok_v1 = '0;
      ok_v2 = '0;
      unique case (kcls_ff)
         CLS_MSS:       ok_v1 = {16'd0, acc1_in[15:0]};
         CLS_WSCALE:    ok_v1 = {24'd0, acc1_in[7:0]};
         CLS_SACK:      ok_v1 = {24'd0, sack_len};
         CLS_TIMESTAMP: begin
            ok_v1 = acc1_in;
            ok_v2 = acc2_in;
         end
         default:       ok_v1 = '0;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      kcls_in   = kcls_ff;
      dlen_in   = dlen_ff;
      remain_in = remain_ff;
      acc1_in   = acc1_ff;
      acc2_in   = acc2_ff;
      emit      = 1'b0;
      rec       = '0;
      unique case (eff_phase)
         PH_KIND: begin
            kind_in   = info.opt_byte;
            kcls_in   = info.byte_class;
            dlen_in   = '0;
            remain_in = '0;
            acc1_in   = '0;
            acc2_in   = '0;
            if (info.is_zero) begin
               phase_in = PH_DONE;
               emit     = 1'b1;
               rec      = '{option_class: CLS_OTHER, option_kind: KIND_EOL,
                            option_length: 8'd0, value_first: 32'd0,
                            value_second: 32'd0, parse_status: ST_EOL,
                            list_done: 1'b1};
            end else if (info.is_one) begin
               phase_in = info.region_last ? PH_DONE : PH_KIND;
               emit     = 1'b1;
               rec      = '{option_class: CLS_NOP, option_kind: KIND_NOP,
                            option_length: 8'd1, value_first: 32'd0,
                            value_second: 32'd0, parse_status: ST_OK,
                            list_done: info.region_last};
            end else if (info.region_last) begin
               phase_in = PH_DONE;
               emit     = 1'b1;
               rec      = '{option_class: info.byte_class, option_kind: info.opt_byte,
                            option_length: 8'd0, value_first: 32'd0,
                            value_second: 32'd0, parse_status: ST_TRUNC,
                            list_done: 1'b1};
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            dlen_in = info.opt_byte;
            if (!len_ok) begin
               phase_in = PH_DONE;
               emit     = 1'b1;
               rec      = '{option_class: kcls_ff, option_kind: kind_ff,
                            option_length: info.opt_byte, value_first: 32'd0,
                            value_second: 32'd0, parse_status: ST_BAD,
                            list_done: 1'b1};
            end else if (info.is_two) begin
               phase_in = info.region_last ? PH_DONE : PH_KIND;
               emit     = 1'b1;
               rec      = '{option_class: kcls_ff, option_kind: kind_ff,
                            option_length: info.opt_byte, value_first: ok_v1,
                            value_second: ok_v2, parse_status: ST_OK,
                            list_done: info.region_last};
            end else begin
               remain_in = info.opt_byte - 8'd2;
               if (info.region_last) begin
                  phase_in = PH_DONE;
                  emit     = 1'b1;
                  rec      = '{option_class: kcls_ff, option_kind: kind_ff,
                               option_length: info.opt_byte, value_first: 32'd0,
                               value_second: 32'd0, parse_status: ST_TRUNC,
                               list_done: 1'b1};
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            // Timestamp: the first four body bytes are the value, the rest the echo.
            if (kcls_ff == CLS_MSS || kcls_ff == CLS_WSCALE ||
                (kcls_ff == CLS_TIMESTAMP && remain_ff > 8'd4)) begin
               acc1_in = {acc1_ff[23:0], info.opt_byte};
            end else if (kcls_ff == CLS_TIMESTAMP) begin
               acc2_in = {acc2_ff[23:0], info.opt_byte};
            end
            remain_in = remain_ff - 8'd1;
            if (remain_in == 8'd0) begin
               phase_in = info.region_last ? PH_DONE : PH_KIND;
               emit     = 1'b1;
               rec      = '{option_class: kcls_ff, option_kind: kind_ff,
                            option_length: dlen_ff, value_first: ok_v1,
                            value_second: ok_v2, parse_status: ST_OK,
                            list_done: info.region_last};
            end else if (info.region_last) begin
               phase_in = PH_DONE;
               emit     = 1'b1;
               rec      = '{option_class: kcls_ff, option_kind: kind_ff,
                            option_length: dlen_ff, value_first: 32'd0,
                            value_second: 32'd0, parse_status: ST_TRUNC,
                            list_done: 1'b1};
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = emit;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_KIND;
         kind_ff      <= '0;
         kcls_ff      <= CLS_OTHER;
         dlen_ff      <= '0;
         remain_ff    <= '0;
         acc1_ff      <= '0;
         acc2_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff  <= phase_in;
            kind_ff   <= kind_in;
            kcls_ff   <= kcls_in;
            dlen_ff   <= dlen_in;
            remain_ff <= remain_in;
            acc1_ff   <= acc1_in;
            acc2_ff   <= acc2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_word_ff <= rec;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.option_class  = rsp_word_ff.option_class;
   assign rsp_ch.option_kind   = rsp_word_ff.option_kind;
   assign rsp_ch.option_length = rsp_word_ff.option_length;
   assign rsp_ch.value_first   = rsp_word_ff.value_first;
   assign rsp_ch.value_second  = rsp_word_ff.value_second;
   assign rsp_ch.parse_status  = rsp_word_ff.parse_status;
   assign rsp_ch.list_done     = rsp_word_ff.list_done;

endmodule

// File: design/tcp_option_parser_top.sv
// Channel   Direction  Word
// req_ch    in         one options byte with first and last marks
// rsp_ch    out        one record per option or end of list, with status and list end
//
// A byte can be accepted every cycle while the queue has room; an accepted byte is
// first written into a queue slot, and the record it completes is loaded into the
// result register when the walker takes that byte from the queue.
// Reset is synchronous and active high; it empties the byte queue and the result
// register and leaves the walker waiting for a kind byte.
// A stalled result holds the walker, and bytes keep filling the queue until it is full.
module tcp_option_parser_top import tcp_opt_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input logic           clock,
   input logic           reset,
   tcp_opt_req_if.sink   req_ch,
   tcp_opt_rsp_if.source rsp_ch
);

   // The front end classifies each byte as it arrives: the class of the byte
   // taken as an option kind, and the length compares that the walker needs.
   // Doing this before the queue keeps the walker's path short.
   logic          push;
   logic          queue_full;
   logic          queue_empty;
   logic          pop;
   byte_info_type push_info;
   byte_info_type pop_info;

   tcp_opt_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_info  (push_info)
   );

   // The queue lets the input side run on while a result waits to be taken.
   tcp_opt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_info (push_info),
      .full      (queue_full),
      .pop       (pop),
      .pop_info  (pop_info),
      .empty     (queue_empty)
   );

   // The walker follows the kind and length records, gathers option values,
   // and loads one result word whenever an option completes or the list ends.
   tcp_opt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .info        (pop_info),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule
